// ===== design/ujse_pkg.sv =====
// Shared types, codes and character helpers of the JSON string escaper.
`default_nettype none
package ujse_pkg;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} ujse_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
		logic       error;
	} ujse_out_t;

	localparam logic [2:0] JOB_NONE = 3'd0;
	localparam logic [2:0] JOB_ERR  = 3'd1;
	localparam logic [2:0] JOB_CHAR = 3'd2;
	localparam logic [2:0] JOB_ESC2 = 3'd3;
	localparam logic [2:0] JOB_U1   = 3'd4;
	localparam logic [2:0] JOB_U2   = 3'd5;

	localparam logic       CMD_DATA = 1'b0;
	localparam logic       CMD_END  = 1'b1;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_U     = 8'h75;

	// One decoded item waiting for the back end to spell it out.
	typedef struct packed {
		logic        quote;
		logic [2:0]  kind;
		logic [7:0]  ch;
		logic [15:0] hi;
		logic [15:0] lo;
	} ujse_job_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'h0, n};
		end else begin
			r = 8'h57 + {4'h0, n};
		end
		return r;
	endfunction

	function automatic logic [3:0] body_len(input logic [2:0] kind);
		logic [3:0] r;
		case (kind)
			JOB_ERR:  r = 4'd1;
			JOB_CHAR: r = 4'd1;
			JOB_ESC2: r = 4'd2;
			JOB_U1:   r = 4'd6;
			JOB_U2:   r = 4'd12;
			default:  r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] body_char(input ujse_job_t job, input logic [3:0] idx);
		logic        sel;
		logic [3:0]  k;
		logic [15:0] v;
		logic [7:0]  r;
		sel = (idx >= 4'd6);
		k   = sel ? (idx - 4'd6) : idx;
		v   = sel ? job.lo : job.hi;
		case (k)
			4'd0:    r = CH_BSL;
			4'd1:    r = CH_U;
			4'd2:    r = hex_char(v[15:12]);
			4'd3:    r = hex_char(v[11:8]);
			4'd4:    r = hex_char(v[7:4]);
			default: r = hex_char(v[3:0]);
		endcase
		case (job.kind)
			JOB_ERR:  r = 8'h00;
			JOB_CHAR: r = job.ch;
			JOB_ESC2: r = (idx == 4'd0) ? CH_BSL : job.ch;
			default:  r = r;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/ujse_front.sv =====
// Front end: UTF-8 decode and classification of each accepted byte into a job.
`default_nettype none
module ujse_front
	import ujse_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire ujse_in_t  item,
	output logic           job_valid,
	output ujse_job_t      job
);

	logic        in_string_q, discarding_q;
	logic [1:0]  pending_q, seq_len_q;
	logic [20:0] cp_q;

	logic        in_string_n, discarding_n;
	logic [1:0]  pending_n, seq_len_n;
	logic [20:0] cp_n;

	logic [7:0]  b;
	logic [20:0] cp_shift;
	logic [19:0] cp_off;
	logic        fail;

	assign b        = item.data_byte;
	assign cp_shift = {cp_q[14:0], b[5:0]};
	assign cp_off   = cp_shift[19:0] - 20'h10000;

	always_comb begin
		in_string_n  = in_string_q;
		discarding_n = discarding_q;
		pending_n    = pending_q;
		seq_len_n    = seq_len_q;
		cp_n         = cp_q;
		fail         = 1'b0;
		job          = '0;
		job.kind     = JOB_NONE;
		if (item.cmd == CMD_END) begin
			in_string_n  = 1'b0;
			discarding_n = 1'b0;
			pending_n    = 2'd0;
			seq_len_n    = 2'd0;
			cp_n         = '0;
			if (discarding_q) begin
				job.kind = JOB_NONE;
			end else if (pending_q != 2'd0) begin
				job.kind = JOB_ERR;
			end else begin
				job.quote = !in_string_q;
				job.kind  = JOB_CHAR;
				job.ch    = CH_QUOTE;
			end
		end else if (!discarding_q) begin
			in_string_n = 1'b1;
			job.quote   = !in_string_q;
			if (pending_q != 2'd0) begin
				if (b[7:6] != 2'b10) begin
					fail = 1'b1;
				end else begin
					cp_n      = cp_shift;
					pending_n = pending_q - 2'd1;
					if (pending_q == 2'd1) begin
						if ((seq_len_q == 2'd1 && cp_shift < 21'h80) ||
							(seq_len_q == 2'd2 && cp_shift < 21'h800) ||
							(seq_len_q == 2'd3 && cp_shift < 21'h10000) ||
							cp_shift > 21'h10ffff) begin
							fail = 1'b1;
						end else if (cp_shift > 21'h00ffff) begin
							job.kind = JOB_U2;
							job.hi   = {6'b110110, cp_off[19:10]};
							job.lo   = {6'b110111, cp_off[9:0]};
						end else begin
							job.kind = JOB_U1;
							job.hi   = cp_shift[15:0];
						end
						seq_len_n = 2'd0;
						cp_n      = '0;
					end
				end
			end else begin
				job.ch = b;
				case (b)
					8'h22, 8'h5c: job.kind = JOB_ESC2;
					8'h08: begin job.kind = JOB_ESC2; job.ch = 8'h62; end
					8'h0c: begin job.kind = JOB_ESC2; job.ch = 8'h66; end
					8'h0a: begin job.kind = JOB_ESC2; job.ch = 8'h6e; end
					8'h0d: begin job.kind = JOB_ESC2; job.ch = 8'h72; end
					8'h09: begin job.kind = JOB_ESC2; job.ch = 8'h74; end
					default: begin
						if (b < 8'h20 || b == 8'h7f) begin
							job.kind = JOB_U1;
							job.hi   = {8'h00, b};
						end else if (b < 8'h80) begin
							job.kind = JOB_CHAR;
						end else if (b < 8'hc2 || b > 8'hf4) begin
							fail = 1'b1;
						end else if (b >= 8'hf0) begin
							cp_n      = {18'd0, b[2:0]};
							pending_n = 2'd3;
							seq_len_n = 2'd3;
						end else if (b >= 8'he0) begin
							cp_n      = {17'd0, b[3:0]};
							pending_n = 2'd2;
							seq_len_n = 2'd2;
						end else begin
							cp_n      = {16'd0, b[4:0]};
							pending_n = 2'd1;
							seq_len_n = 2'd1;
						end
					end
				endcase
			end
			if (fail) begin
				job          = '0;
				job.kind     = JOB_ERR;
				discarding_n = 1'b1;
				pending_n    = 2'd0;
				seq_len_n    = 2'd0;
				cp_n         = '0;
			end
		end
		job_valid = accept && (job.quote || job.kind != JOB_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q  <= 1'b0;
			discarding_q <= 1'b0;
			pending_q    <= 2'd0;
			seq_len_q    <= 2'd0;
			cp_q         <= '0;
		end else if (accept) begin
			in_string_q  <= in_string_n;
			discarding_q <= discarding_n;
			pending_q    <= pending_n;
			seq_len_q    <= seq_len_n;
			cp_q         <= cp_n;
		end
	end

endmodule
`default_nettype wire

// ===== design/ujse_fifo.sv =====
// Short job queue between the decoding front end and the spelling back end.
`default_nettype none
module ujse_fifo
	import ujse_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr,
	input  wire ujse_job_t wr_job,
	output logic           full,
	input  wire logic      rd,
	output ujse_job_t      head,
	output logic           empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	ujse_job_t     slot_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == LAST_IDX) ? '0 : wptr_q + AW'(1);
			end
			if (rd) begin
				rptr_q <= (rptr_q == LAST_IDX) ? '0 : rptr_q + AW'(1);
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/ujse_back.sv =====
// Back end: spells a job into the result register, one character per cycle unless pop stalls.
`default_nettype none
module ujse_back
	import ujse_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ujse_job_t head,
	input  wire logic      head_empty,
	output logic           head_pop,
	input  wire logic      pop,
	output logic           empty,
	output ujse_out_t      result
);

	logic       qdone_q;
	logic [3:0] idx_q;
	logic       out_valid_q;
	ujse_out_t  out_q;

	logic       load;
	logic       send_quote;
	logic [3:0] len;
	ujse_out_t  nxt;

	assign len        = body_len(head.kind);
	assign load       = !head_empty && (!out_valid_q || pop);
	assign send_quote = head.quote && !qdone_q;

	always_comb begin
		if (send_quote) begin
			nxt.out_char = CH_QUOTE;
			nxt.last     = (len == 4'd0);
			nxt.error    = 1'b0;
		end else begin
			nxt.out_char = body_char(head, idx_q);
			nxt.last     = (idx_q == len - 4'd1);
			nxt.error    = (head.kind == JOB_ERR);
		end
	end

	assign head_pop = load && nxt.last;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qdone_q     <= 1'b0;
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (nxt.last) begin
					qdone_q <= 1'b0;
					idx_q   <= 4'd0;
				end else if (send_quote) begin
					qdone_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== design/utf8_json_string_escaper.sv =====
// Top level of the UTF-8 checking JSON string escaper.
`default_nettype none
// The escaper takes a string as a stream of bytes, each item carrying either a
// data byte or an end-of-string command, and returns the quoted JSON text of
// the string in pure ASCII, one character per result transfer, with last set
// on the final character caused by each input item. Quote and backslash are
// escaped with a backslash, the usual control characters get short escapes,
// other control bytes and 127 become a lower-case \u00xx, and multi-byte UTF-8
// is decoded, validated and sent as \uxxxx or as a surrogate pair. Invalid
// UTF-8 produces a single result with error set and out_char zero, after which
// bytes are dropped until the end command. A front end decodes each input
// transfer combinationally and places a job in a queue of FIFO_DEPTH entries;
// a back end spells each job out at one character per cycle, unless pop
// stalls, into a result register. Input is taken every cycle while the queue
// has room, so plain bytes flow at one per cycle while results are popped; a
// byte that expands to n characters (up to twelve, including any opening quote)
// holds the back end until all n are spelled, which sets the sustained rate.
// There is no clearing pass after reset; the block is ready at once.
module utf8_json_string_escaper
	import ujse_pkg::*;
#(
	parameter int FIFO_DEPTH = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	output logic           full,
	input  wire ujse_in_t  item,
	input  wire logic      pop,
	output logic           empty,
	output ujse_out_t      result
);

	logic      accept;
	logic      job_valid;
	ujse_job_t job;
	ujse_job_t head;
	logic      head_empty;
	logic      head_pop;

	// An input transfer is decoded and its job queued in the same cycle.
	assign accept = push && !full;

	ujse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.job_valid (job_valid),
		.job       (job)
	);

	ujse_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_valid),
		.wr_job (job),
		.full   (full),
		.rd     (head_pop),
		.head   (head),
		.empty  (head_empty)
	);

	// The back end reads the queue head in place and releases it as the
	// job's final character moves into the result register.
	ujse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule
`default_nettype wire
